[rtl/bbcd_pkg.sv]
// ---------------------------------------------------------------------------
// Black border crop detect package
// Shared widths, register map, statistics record and small helper functions.
// ---------------------------------------------------------------------------
package bbcd_pkg;

   localparam int BBCD_MAX_DIM = 4096;
   localparam int LUMA_W       = 8;
   localparam int CFG_W        = 13;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 3;

   localparam logic [LUMA_W-1:0] BRIGHT_LEVEL = LUMA_W'(24);

   typedef logic [CFG_W-1:0] bbcd_cfg_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_LIMIT_TOP    = 3'd2,
      REG_LIMIT_BOTTOM = 3'd3,
      REG_LIMIT_LEFT   = 3'd4,
      REG_LIMIT_RIGHT  = 3'd5
   } bbcd_reg_type;

   // Bright-pixel statistics of one finished frame.
   typedef struct packed {
      logic         any_bright;
      bbcd_cfg_type first_row;
      bbcd_cfg_type last_row;
      bbcd_cfg_type min_col;
      bbcd_cfg_type max_col;
   } bbcd_stats_type;

   function automatic bbcd_cfg_type min_cfg(input bbcd_cfg_type a, input bbcd_cfg_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic bbcd_cfg_type sat_sub_cfg(input bbcd_cfg_type a, input bbcd_cfg_type b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic bbcd_cfg_type crop_value(input bbcd_cfg_type limit,
                                               input bbcd_cfg_type count,
                                               input bbcd_cfg_type dim);
      return min_cfg(limit, min_cfg(count, dim));
   endfunction

endpackage

[rtl/bbcd_if.sv]
// ---------------------------------------------------------------------------
// Black border crop detect channels
// Request channel (luma samples) and response channel (crop counts).
// ---------------------------------------------------------------------------
interface bbcd_req_if;
   logic                        valid;
   logic                        ready;
   logic [bbcd_pkg::LUMA_W-1:0] luma;
   logic                        frame_start;

   modport source (output valid, output luma, output frame_start, input ready);
   modport sink   (input valid, input luma, input frame_start, output ready);
endinterface

interface bbcd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bbcd_pkg::CFG_W-1:0] crop_top;
   logic [bbcd_pkg::CFG_W-1:0] crop_bottom;
   logic [bbcd_pkg::CFG_W-1:0] crop_left;
   logic [bbcd_pkg::CFG_W-1:0] crop_right;

   modport source (output valid, output crop_top, output crop_bottom,
                   output crop_left, output crop_right, input ready);
   modport sink   (input valid, input crop_top, input crop_bottom,
                   input crop_left, input crop_right, output ready);
endinterface

[rtl/bbcd_tracker.sv]
// ---------------------------------------------------------------------------
// Black border crop detect: raster tracker
// Follows the pixel position and the extent of bright pixels in the frame,
// and holds the statistics of a finished frame until they are taken.
// ---------------------------------------------------------------------------
module bbcd_tracker #(
   parameter int MAX_DIM = bbcd_pkg::BBCD_MAX_DIM
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [bbcd_pkg::LUMA_W-1:0] luma,
   input  logic                        frame_start,
   input  bbcd_pkg::bbcd_cfg_type      w_last,
   input  bbcd_pkg::bbcd_cfg_type      h_last,
   input  logic                        snap_take,
   output logic                        snap_valid,
   output bbcd_pkg::bbcd_stats_type    snap
);
   import bbcd_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [CNT_W-1:0] CNT_ONES = '1;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             any_ff, any_in;
   logic [CNT_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0] min_ff, min_in;
   logic [CNT_W-1:0] max_ff, max_in;
   logic             snap_valid_ff, snap_valid_in;
   bbcd_stats_type   snap_ff, snap_in;

   always_comb begin
      logic [CNT_W-1:0] b_col, b_row, b_first, b_last, b_min, b_max;
      logic [CNT_W-1:0] n_first, n_last, n_min, n_max;
      logic             b_any, n_any, bright, last_col, last_row;

      // A frame start restarts the position and the bright tracking at this pixel.
      b_col   = frame_start ? '0 : col_ff;
      b_row   = frame_start ? '0 : row_ff;
      b_any   = frame_start ? 1'b0 : any_ff;
      b_first = frame_start ? '0 : first_ff;
      b_last  = frame_start ? '0 : last_ff;
      b_min   = frame_start ? CNT_ONES : min_ff;
      b_max   = frame_start ? '0 : max_ff;

      bright  = (luma >= BRIGHT_LEVEL);
      n_any   = b_any | bright;
      n_first = (bright && !b_any) ? b_row : b_first;
      n_last  = bright ? b_row : b_last;
      n_min   = (bright && (b_col < b_min)) ? b_col : b_min;
      n_max   = (bright && (b_col > b_max)) ? b_col : b_max;

      last_col = (CMP_W'(b_col) >= CMP_W'(w_last));
      last_row = (CMP_W'(b_row) >= CMP_W'(h_last));

      col_in        = col_ff;
      row_in        = row_ff;
      any_in        = any_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      snap_valid_in = snap_valid_ff & ~snap_take;
      snap_in       = snap_ff;

      if (advance) begin
         if (last_col && last_row) begin
            snap_valid_in      = 1'b1;
            snap_in.any_bright = n_any;
            snap_in.first_row  = CFG_W'(n_first);
            snap_in.last_row   = CFG_W'(n_last);
            snap_in.min_col    = CFG_W'(n_min);
            snap_in.max_col    = CFG_W'(n_max);
            col_in   = '0;
            row_in   = '0;
            any_in   = 1'b0;
            first_in = '0;
            last_in  = '0;
            min_in   = CNT_ONES;
            max_in   = '0;
         end else begin
            any_in   = n_any;
            first_in = n_first;
            last_in  = n_last;
            min_in   = n_min;
            max_in   = n_max;
            if (last_col) begin
               col_in = '0;
               row_in = b_row + CNT_W'(1);
            end else begin
               col_in = b_col + CNT_W'(1);
               row_in = b_row;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         any_ff        <= 1'b0;
         first_ff      <= '0;
         last_ff       <= '0;
         min_ff        <= CNT_ONES;
         max_ff        <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         any_ff        <= any_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

[rtl/black_border_crop_detect.sv]
// ---------------------------------------------------------------------------
// Black border crop detect
// Measures the dark rows and columns around a luma frame and reports the
// crop count of each side, capped by per-side limit registers.
// ---------------------------------------------------------------------------
// The block takes one luma sample per clock in raster order. It stalls the
// request side only while a finished frame's statistics wait in the raster
// tracker and the response register still holds an untaken result. Each
// request is absorbed by the raster tracker; the request carrying the last
// pixel of a frame stores the frame statistics at its accepting edge, and
// the response register is loaded from those statistics once it is free,
// through one register stage of compares and a subtract. Register writes
// must be made only while no frame result is in flight. No clearing pass
// follows reset.
module black_border_crop_detect #(
   parameter int MAX_DIM = bbcd_pkg::BBCD_MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   bbcd_req_if.sink                        req_if,
   bbcd_rsp_if.source                      rsp_if,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bbcd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bbcd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bbcd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import bbcd_pkg::*;

   localparam logic [31:0] DIM_LIM = 32'(MAX_DIM);

   bbcd_cfg_type   frame_width_ff, frame_width_in;
   bbcd_cfg_type   frame_height_ff, frame_height_in;
   bbcd_cfg_type   limit_top_ff, limit_top_in;
   bbcd_cfg_type   limit_bottom_ff, limit_bottom_in;
   bbcd_cfg_type   limit_left_ff, limit_left_in;
   bbcd_cfg_type   limit_right_ff, limit_right_in;

   bbcd_cfg_type   w_eff, h_eff;
   logic           csr_write;
   bbcd_reg_type   reg_idx;

   logic           snap_valid, snap_take, out_free, req_accept;
   bbcd_stats_type snap;

   logic           rsp_valid_ff, rsp_valid_in;
   bbcd_cfg_type   rsp_top_ff, rsp_top_in;
   bbcd_cfg_type   rsp_bottom_ff, rsp_bottom_in;
   bbcd_cfg_type   rsp_left_ff, rsp_left_in;
   bbcd_cfg_type   rsp_right_ff, rsp_right_in;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = bbcd_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      limit_top_in    = limit_top_ff;
      limit_bottom_in = limit_bottom_ff;
      limit_left_in   = limit_left_ff;
      limit_right_in  = limit_right_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[CFG_W-1:0];
            REG_LIMIT_TOP:    limit_top_in    = csr_pwdata[CFG_W-1:0];
            REG_LIMIT_BOTTOM: limit_bottom_in = csr_pwdata[CFG_W-1:0];
            REG_LIMIT_LEFT:   limit_left_in   = csr_pwdata[CFG_W-1:0];
            REG_LIMIT_RIGHT:  limit_right_in  = csr_pwdata[CFG_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         REG_LIMIT_TOP:    csr_prdata = CSR_DATA_W'(limit_top_ff);
         REG_LIMIT_BOTTOM: csr_prdata = CSR_DATA_W'(limit_bottom_ff);
         REG_LIMIT_LEFT:   csr_prdata = CSR_DATA_W'(limit_left_ff);
         REG_LIMIT_RIGHT:  csr_prdata = CSR_DATA_W'(limit_right_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_W'(1920);
         frame_height_ff <= CFG_W'(1080);
         limit_top_ff    <= '0;
         limit_bottom_ff <= '0;
         limit_left_ff   <= '0;
         limit_right_ff  <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         limit_top_ff    <= limit_top_in;
         limit_bottom_ff <= limit_bottom_in;
         limit_left_ff   <= limit_left_in;
         limit_right_ff  <= limit_right_in;
      end
   end

   // A size of zero acts as one, and a size beyond the largest frame acts as that.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (32'(frame_width_ff) > DIM_LIM) begin
         w_eff = CFG_W'(DIM_LIM);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (32'(frame_height_ff) > DIM_LIM) begin
         h_eff = CFG_W'(DIM_LIM);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // Handshake: the tracker holds one finished frame, the response register another.
   assign out_free     = ~rsp_valid_ff | rsp_if.ready;
   assign snap_take    = snap_valid & out_free;
   assign req_if.ready = ~snap_valid | out_free;
   assign req_accept   = req_if.valid & req_if.ready;

   bbcd_tracker #(
      .MAX_DIM (MAX_DIM)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_accept),
      .luma        (req_if.luma),
      .frame_start (req_if.frame_start),
      .w_last      (w_eff - CFG_W'(1)),
      .h_last      (h_eff - CFG_W'(1)),
      .snap_take   (snap_take),
      .snap_valid  (snap_valid),
      .snap        (snap)
   );

   always_comb begin
      bbcd_cfg_type top_cnt, bottom_cnt, left_cnt, right_cnt;

      // With no bright pixel the whole frame counts as border.
      if (snap.any_bright) begin
         top_cnt    = snap.first_row;
         bottom_cnt = sat_sub_cfg(h_eff - CFG_W'(1), snap.last_row);
         left_cnt   = snap.min_col;
         right_cnt  = sat_sub_cfg(w_eff - CFG_W'(1), snap.max_col);
      end else begin
         top_cnt    = h_eff;
         bottom_cnt = h_eff;
         left_cnt   = w_eff;
         right_cnt  = w_eff;
      end

      rsp_valid_in  = rsp_valid_ff & ~rsp_if.ready;
      rsp_top_in    = rsp_top_ff;
      rsp_bottom_in = rsp_bottom_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      if (snap_take) begin
         rsp_valid_in  = 1'b1;
         rsp_top_in    = crop_value(limit_top_ff, top_cnt, h_eff);
         rsp_bottom_in = crop_value(limit_bottom_ff, bottom_cnt, h_eff);
         rsp_left_in   = crop_value(limit_left_ff, left_cnt, w_eff);
         rsp_right_in  = crop_value(limit_right_ff, right_cnt, w_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_top_ff    <= rsp_top_in;
      rsp_bottom_ff <= rsp_bottom_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.crop_top    = rsp_top_ff;
   assign rsp_if.crop_bottom = rsp_bottom_ff;
   assign rsp_if.crop_left   = rsp_left_ff;
   assign rsp_if.crop_right  = rsp_right_ff;

   // Checks.
   a_crop_within_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_top_ff <= limit_top_ff) && (rsp_bottom_ff <= limit_bottom_ff) &&
                       (rsp_left_ff <= limit_left_ff) && (rsp_right_ff <= limit_right_ff))
      else $error("crop count exceeds its limit register");

   a_crop_within_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_top_ff <= h_eff) && (rsp_bottom_ff <= h_eff) &&
                       (rsp_left_ff <= w_eff) && (rsp_right_ff <= w_eff))
      else $error("crop count exceeds the frame size");

   a_take_loads_response : assert property (@(posedge clock) disable iff (reset)
      snap_take |=> rsp_valid_ff)
      else $error("taken frame statistics did not reach the response register");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(snap_valid && !snap_take))
      else $error("request accepted while a finished frame was blocked");

endmodule
